// File: hw/rtl/rsch_pkg.sv
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared types and constants for the ray/sphere closest-hit block.
// ----------------------------------------------------------------------------
package rsch_pkg;

    localparam logic [30:0] T_MAX       = 31'h7FFF_FFFF;
    localparam logic [7:0]  SQRT_STEPS  = 8'd64;
    localparam logic [7:0]  NRM_STEPS   = 8'd45;
    localparam logic [7:0]  NUM_BITS    = 8'd62;
    localparam logic        REG_SPHERES = 1'b0;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic        [30:0] radius;
    } sphere_t;

    typedef struct packed {
        logic       start;
        logic       op_sqrt;
        logic [7:0] steps;
    } rsch_ctl_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] q;
    } rsch_res_t;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_READ  = 15'b000000000000010,
        ST_PREP  = 15'b000000000000100,
        ST_MABC  = 15'b000000000001000,
        ST_CHK   = 15'b000000000010000,
        ST_MDISC = 15'b000000000100000,
        ST_SQRT  = 15'b000000001000000,
        ST_DIV   = 15'b000000010000000,
        ST_NEXT  = 15'b000000100000000,
        ST_MSTEP = 15'b000001000000000,
        ST_NORM  = 15'b000010000000000,
        ST_MLEN  = 15'b000100000000000,
        ST_LSQRT = 15'b001000000000000,
        ST_NDIV  = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } state_t;

endpackage

// File: hw/rtl/rsch_divsqrt.sv
// ----------------------------------------------------------------------------
// rsch_divsqrt
// Bit-serial restoring divider and integer square root, one digit per cycle.
// ----------------------------------------------------------------------------
module rsch_divsqrt
    import rsch_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  rsch_ctl_t    ctl,
    input  logic [127:0] x_in,
    input  logic [61:0]  d_in,
    output rsch_res_t    res
);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic         op_reg;
    logic [7:0]   cnt_reg;
    logic [127:0] x_reg;
    logic [67:0]  rem_reg;
    logic [63:0]  q_reg;
    logic [61:0]  d_reg;
    logic         sat_reg;

    logic [67:0]  rem_sh, trial, rem_n;
    logic [63:0]  q_n;
    logic         ge;

    always_comb begin
        rem_sh = op_reg ? {rem_reg[65:0], x_reg[127:126]} : {rem_reg[66:0], x_reg[127]};
        trial  = op_reg ? {2'b00, q_reg, 2'b01} : {6'b0, d_reg};
        ge     = rem_sh >= trial;
        rem_n  = ge ? rem_sh - trial : rem_sh;
        q_n    = {q_reg[62:0], ge};
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == 8'd1) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        if (ctl.start) begin
            op_reg  <= ctl.op_sqrt;
            cnt_reg <= ctl.steps;
            x_reg   <= x_in;
            d_reg   <= d_in;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 8'd1;
            x_reg   <= op_reg ? {x_reg[125:0], 2'b00} : {x_reg[126:0], 1'b0};
            rem_reg <= rem_n;
            q_reg   <= q_n;
            sat_reg <= sat_reg | (q_n[63:31] != '0);
        end
    end

    assign res.done = done_reg;
    assign res.sat  = sat_reg;
    assign res.q    = q_reg;

endmodule

// File: hw/rtl/ray_sphere_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit
// Sphere table with a closest-hit ray tracer built on one shared multiplier
// and one bit-serial divide/square-root unit.
//
//   channel | direction | handshake          | word
//   s_      | in        | s_valid / s_ready  | table write or ray
//   m_      | out       | m_valid / m_ready  | hit record
//   apb     | in        | psel/penable/pready| spheres_in_use at 0x0
//
// Each sphere in use costs a ray the quadratic terms and the early reject; one
// that passes adds the discriminant, the root and the divide. A hit then adds
// the hit point and normal, set by the root and three divides. Reset is
// synchronous on aresetn low and clears control state only. The result sits in
// an output register; a new word is taken while it waits, and a ray stalls at
// its end until it drains.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit
    import rsch_pkg::*;
#(
    parameter int MAX_SPHERES = 64,
    parameter int FRAC_BITS   = 16
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [5:0]         s_entry_index,
    input  logic signed [31:0] s_center_x,
    input  logic signed [31:0] s_center_y,
    input  logic signed [31:0] s_center_z,
    input  logic [30:0]        s_sphere_radius,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic signed [31:0] s_origin_z,
    input  logic signed [31:0] s_dir_x,
    input  logic signed [31:0] s_dir_y,
    input  logic signed [31:0] s_dir_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [5:0]         m_hit_index,
    output logic [30:0]        m_hit_distance,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_point_y,
    output logic signed [31:0] m_point_z,
    output logic signed [15:0] m_normal_x,
    output logic signed [15:0] m_normal_y,
    output logic signed [15:0] m_normal_z
);

    localparam int          AW      = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam logic [10:0] MAX_CNT = 11'(MAX_SPHERES);

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [65:0] mag67(input logic signed [66:0] v);
        mag67 = v[66] ? 66'(-v) : 66'(v);
    endfunction

    // table
    sphere_t          mem [MAX_SPHERES];
    sphere_t          rd_data_reg;
    sphere_t          wr_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr, rd_addr;

    // control
    state_t           state_reg, state_next;
    logic [6:0]       spheres_reg, spheres_next;
    logic [10:0]      cnt_reg, cnt_next, idx_reg, idx_next;
    logic [3:0]       mcnt_reg, mcnt_next;
    logic [1:0]       axis_reg, axis_next;
    logic             launched_reg, launched_next;
    logic             have_reg, have_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic signed [31:0] org_reg [3], org_next [3];
    logic signed [31:0] dir_reg [3], dir_next [3];
    logic signed [30:0] ds_reg [3], ds_next [3];
    logic signed [30:0] os_reg [3], os_next [3];
    logic signed [32:0] o_reg [3], o_next [3];
    logic signed [32:0] best_o_reg [3], best_o_next [3];
    logic [1:0]         sd_reg, sd_next, so_reg, so_next;
    logic [29:0]        rs_reg, rs_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [63:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next, acc_c_reg, acc_c_next;
    logic [61:0]        bm_reg, bm_next, cm_reg, cm_next, am_reg, am_next, num_reg, num_next;
    logic               cneg_reg, cneg_next;
    logic signed [128:0] disc_reg, disc_next;
    logic [30:0]        t_reg, t_next, best_reg, best_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic signed [31:0] pt_reg [3], pt_next [3];
    logic               rneg_reg [3], rneg_next [3];
    logic [65:0]        nm_reg [3], nm_next [3];
    logic [63:0]        len2_reg, len2_next;
    logic [31:0]        len_reg, len_next;
    logic signed [15:0] nrm_reg [3], nrm_next [3];

    logic               o_hit_reg, o_hit_next;
    logic [5:0]         o_idx_reg, o_idx_next;
    logic [30:0]        o_dist_reg, o_dist_next;
    logic signed [31:0] o_pt_reg [3], o_pt_next [3];
    logic signed [15:0] o_nrm_reg [3], o_nrm_next [3];

    // shared units
    logic signed [32:0] mul_x, mul_y;
    rsch_ctl_t          ctl;
    logic [127:0]       ux;
    logic [61:0]        ud;
    rsch_res_t          ures;

    // scratch
    logic               in_acc;
    logic [10:0]        req_cnt;
    logic [31:0]        dmag [3];
    logic [31:0]        dor, dsh;
    logic [32:0]        omag [3];
    logic [32:0]        mor, osh;
    logic [3:0]         pidx;
    logic [128:0]       term;
    logic signed [65:0] step;
    logic signed [66:0] psum, rsum;
    logic [65:0]        nor_all;
    logic [7:0]         kshift;
    logic [44:0]        ndiv;
    logic [15:0]        qn;

    rsch_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .x_in    (ux),
        .d_in    (ud),
        .res     (ures)
    );

    assign pready  = 1'b1;
    assign prdata  = (psel && paddr[2] == REG_SPHERES) ? {25'b0, spheres_reg} : 32'b0;
    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;

    assign wr_en   = in_acc && !s_mode && ({5'b0, s_entry_index} < MAX_CNT);
    assign wr_addr = AW'(s_entry_index);
    assign wr_data = '{cx: s_center_x, cy: s_center_y, cz: s_center_z, radius: s_sphere_radius};
    assign rd_addr = idx_reg[AW-1:0];

    assign prod_next = mul_x * mul_y;
    assign kshift    = 8'(FRAC_BITS) + {6'b0, so_reg} - {6'b0, sd_reg};
    assign req_cnt   = ({4'b0, spheres_reg} > MAX_CNT) ? MAX_CNT : {4'b0, spheres_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        spheres_next = spheres_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_SPHERES) begin
            spheres_next = pwdata[6:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        mcnt_next      = mcnt_reg;
        axis_next      = axis_reg;
        launched_next  = launched_reg;
        have_next      = have_reg;
        out_valid_next = out_valid_reg;
        org_next       = org_reg;
        dir_next       = dir_reg;
        ds_next        = ds_reg;
        os_next        = os_reg;
        o_next         = o_reg;
        best_o_next    = best_o_reg;
        sd_next        = sd_reg;
        so_next        = so_reg;
        rs_next        = rs_reg;
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        acc_c_next     = acc_c_reg;
        bm_next        = bm_reg;
        cm_next        = cm_reg;
        am_next        = am_reg;
        num_next       = num_reg;
        cneg_next      = cneg_reg;
        disc_next      = disc_reg;
        t_next         = t_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        pt_next        = pt_reg;
        rneg_next      = rneg_reg;
        nm_next        = nm_reg;
        len2_next      = len2_reg;
        len_next       = len_reg;
        nrm_next       = nrm_reg;
        o_hit_next     = o_hit_reg;
        o_idx_next     = o_idx_reg;
        o_dist_next    = o_dist_reg;
        o_pt_next      = o_pt_reg;
        o_nrm_next     = o_nrm_reg;
        mul_x          = '0;
        mul_y          = '0;
        ctl            = '0;
        ux             = '0;
        ud             = '0;
        pidx           = mcnt_reg - 4'd1;
        term           = '0;
        step           = '0;
        psum           = '0;
        rsum           = '0;
        nor_all        = '0;
        ndiv           = '0;
        qn             = '0;
        dor            = '0;
        dsh            = '0;
        mor            = '0;
        osh            = '0;
        for (int j = 0; j < 3; j++) begin
            dmag[j] = '0;
            omag[j] = '0;
        end

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_mode) begin
                    org_next[0] = s_origin_x;
                    org_next[1] = s_origin_y;
                    org_next[2] = s_origin_z;
                    dir_next[0] = s_dir_x;
                    dir_next[1] = s_dir_y;
                    dir_next[2] = s_dir_z;
                    for (int j = 0; j < 3; j++) begin
                        dmag[j] = mag32(dir_next[j]);
                    end
                    dor = dmag[0] | dmag[1] | dmag[2];
                    sd_next = dor[31] ? 2'd2 : (dor[30] ? 2'd1 : 2'd0);
                    for (int j = 0; j < 3; j++) begin
                        dsh = dmag[j] >> sd_next;
                        ds_next[j] = dir_next[j][31] ? -$signed({1'b0, dsh[29:0]})
                                                     : $signed({1'b0, dsh[29:0]});
                    end
                    cnt_next      = req_cnt;
                    idx_next      = '0;
                    have_next     = 1'b0;
                    best_next     = '0;
                    best_idx_next = '0;
                    state_next    = (req_cnt == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                o_next[0] = 33'(org_reg[0]) - 33'(rd_data_reg.cx);
                o_next[1] = 33'(org_reg[1]) - 33'(rd_data_reg.cy);
                o_next[2] = 33'(org_reg[2]) - 33'(rd_data_reg.cz);
                for (int j = 0; j < 3; j++) begin
                    omag[j] = mag33(o_next[j]);
                end
                mor = omag[0] | omag[1] | omag[2] | {2'b0, rd_data_reg.radius};
                so_next = mor[32] ? 2'd3 : (mor[31] ? 2'd2 : (mor[30] ? 2'd1 : 2'd0));
                for (int j = 0; j < 3; j++) begin
                    osh = omag[j] >> so_next;
                    os_next[j] = o_next[j][32] ? -$signed({1'b0, osh[29:0]})
                                               : $signed({1'b0, osh[29:0]});
                end
                osh        = {2'b0, rd_data_reg.radius} >> so_next;
                rs_next    = osh[29:0];
                acc_a_next = '0;
                acc_b_next = '0;
                acc_c_next = '0;
                mcnt_next  = '0;
                state_next = ST_MABC;
            end
            ST_MABC: begin
                if (mcnt_reg != '0) begin
                    if (pidx < 4'd3) begin
                        acc_a_next = acc_a_reg + 64'(prod_reg);
                    end else if (pidx < 4'd6) begin
                        acc_b_next = acc_b_reg + 64'(prod_reg);
                    end else if (pidx < 4'd9) begin
                        acc_c_next = acc_c_reg + 64'(prod_reg);
                    end else begin
                        acc_c_next = acc_c_reg - 64'(prod_reg);
                    end
                end
                unique case (mcnt_reg)
                    4'd0: begin mul_x = 33'(ds_reg[0]); mul_y = 33'(ds_reg[0]); end
                    4'd1: begin mul_x = 33'(ds_reg[1]); mul_y = 33'(ds_reg[1]); end
                    4'd2: begin mul_x = 33'(ds_reg[2]); mul_y = 33'(ds_reg[2]); end
                    4'd3: begin mul_x = 33'(ds_reg[0]); mul_y = 33'(os_reg[0]); end
                    4'd4: begin mul_x = 33'(ds_reg[1]); mul_y = 33'(os_reg[1]); end
                    4'd5: begin mul_x = 33'(ds_reg[2]); mul_y = 33'(os_reg[2]); end
                    4'd6: begin mul_x = 33'(os_reg[0]); mul_y = 33'(os_reg[0]); end
                    4'd7: begin mul_x = 33'(os_reg[1]); mul_y = 33'(os_reg[1]); end
                    4'd8: begin mul_x = 33'(os_reg[2]); mul_y = 33'(os_reg[2]); end
                    4'd9: begin mul_x = {3'b0, rs_reg}; mul_y = {3'b0, rs_reg}; end
                    default: begin mul_x = '0; mul_y = '0; end
                endcase
                mcnt_next = mcnt_reg + 4'd1;
                if (mcnt_reg == 4'd10) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (acc_a_reg == '0 || !acc_b_reg[63]) begin
                    t_next     = '0;
                    state_next = ST_NEXT;
                end else begin
                    bm_next    = 62'(-acc_b_reg);
                    cm_next    = acc_c_reg[63] ? 62'(-acc_c_reg) : 62'(acc_c_reg);
                    cneg_next  = acc_c_reg[63];
                    am_next    = acc_a_reg[61:0];
                    disc_next  = '0;
                    mcnt_next  = '0;
                    state_next = ST_MDISC;
                end
            end
            ST_MDISC: begin
                if (mcnt_reg != '0) begin
                    term = {63'b0, prod_reg};
                    unique case (pidx)
                        4'd1:         term = term << 32;
                        4'd2, 4'd6:   term = term << 62;
                        4'd4, 4'd5:   term = term << 31;
                        default:      term = term;
                    endcase
                    if (pidx < 4'd3 || cneg_reg) begin
                        disc_next = disc_reg + $signed(term);
                    end else begin
                        disc_next = disc_reg - $signed(term);
                    end
                end
                unique case (mcnt_reg)
                    4'd0: begin mul_x = {2'b0, bm_reg[30:0]};  mul_y = {2'b0, bm_reg[30:0]};  end
                    4'd1: begin mul_x = {2'b0, bm_reg[30:0]};  mul_y = {2'b0, bm_reg[61:31]}; end
                    4'd2: begin mul_x = {2'b0, bm_reg[61:31]}; mul_y = {2'b0, bm_reg[61:31]}; end
                    4'd3: begin mul_x = {2'b0, am_reg[30:0]};  mul_y = {2'b0, cm_reg[30:0]};  end
                    4'd4: begin mul_x = {2'b0, am_reg[30:0]};  mul_y = {2'b0, cm_reg[61:31]}; end
                    4'd5: begin mul_x = {2'b0, am_reg[61:31]}; mul_y = {2'b0, cm_reg[30:0]};  end
                    4'd6: begin mul_x = {2'b0, am_reg[61:31]}; mul_y = {2'b0, cm_reg[61:31]}; end
                    default: begin mul_x = '0; mul_y = '0; end
                endcase
                mcnt_next = mcnt_reg + 4'd1;
                if (mcnt_reg == 4'd7) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (disc_reg[128]) begin
                    t_next     = '0;
                    state_next = ST_NEXT;
                end else if (!launched_reg) begin
                    ctl.start     = 1'b1;
                    ctl.op_sqrt   = 1'b1;
                    ctl.steps     = SQRT_STEPS;
                    ux            = disc_reg[127:0];
                    launched_next = 1'b1;
                end else if (ures.done) begin
                    launched_next = 1'b0;
                    if ({2'b0, bm_reg} <= ures.q) begin
                        t_next     = '0;
                        state_next = ST_NEXT;
                    end else begin
                        num_next   = bm_reg - ures.q[61:0];
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!launched_reg) begin
                    ctl.start     = 1'b1;
                    ctl.steps     = NUM_BITS + kshift;
                    ux            = {num_reg, 66'b0};
                    ud            = am_reg;
                    launched_next = 1'b1;
                end else if (ures.done) begin
                    launched_next = 1'b0;
                    t_next        = ures.sat ? T_MAX : ures.q[30:0];
                    state_next    = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (t_reg != '0 && (!have_reg || t_reg < best_reg)) begin
                    have_next     = 1'b1;
                    best_next     = t_reg;
                    best_idx_next = idx_reg[AW-1:0];
                    best_o_next   = o_reg;
                end
                idx_next = idx_reg + 11'd1;
                if (idx_next == cnt_reg) begin
                    mcnt_next  = '0;
                    state_next = have_next ? ST_MSTEP : ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_MSTEP: begin
                if (mcnt_reg != '0) begin
                    step = prod_reg >>> FRAC_BITS;
                    psum = 67'(org_reg[pidx[1:0]]) + 67'(step);
                    rsum = 67'(best_o_reg[pidx[1:0]]) + 67'(step);
                    if (psum[66:31] != {36{psum[66]}}) begin
                        pt_next[pidx[1:0]] = psum[66] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else begin
                        pt_next[pidx[1:0]] = psum[31:0];
                    end
                    rneg_next[pidx[1:0]] = rsum[66];
                    nm_next[pidx[1:0]]   = mag67(rsum);
                end
                if (mcnt_reg < 4'd3) begin
                    mul_x = 33'(dir_reg[mcnt_reg[1:0]]);
                    mul_y = {2'b0, best_reg};
                end
                mcnt_next = mcnt_reg + 4'd1;
                if (mcnt_reg == 4'd3) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                nor_all = nm_reg[0] | nm_reg[1] | nm_reg[2];
                if (nor_all[65:30] != '0) begin
                    for (int j = 0; j < 3; j++) begin
                        nm_next[j] = nm_reg[j] >> 1;
                    end
                end else begin
                    len2_next  = '0;
                    mcnt_next  = '0;
                    state_next = ST_MLEN;
                end
            end
            ST_MLEN: begin
                if (mcnt_reg != '0) begin
                    len2_next = len2_reg + 64'(prod_reg);
                end
                if (mcnt_reg < 4'd3) begin
                    mul_x = {3'b0, nm_reg[mcnt_reg[1:0]][29:0]};
                    mul_y = {3'b0, nm_reg[mcnt_reg[1:0]][29:0]};
                end
                mcnt_next = mcnt_reg + 4'd1;
                if (mcnt_reg == 4'd3) begin
                    state_next = ST_LSQRT;
                end
            end
            ST_LSQRT: begin
                if (!launched_reg) begin
                    ctl.start     = 1'b1;
                    ctl.op_sqrt   = 1'b1;
                    ctl.steps     = SQRT_STEPS;
                    ux            = {64'b0, len2_reg};
                    launched_next = 1'b1;
                end else if (ures.done) begin
                    launched_next = 1'b0;
                    len_next      = ures.q[31:0];
                    axis_next     = '0;
                    if (ures.q[31:0] == '0) begin
                        for (int j = 0; j < 3; j++) begin
                            nrm_next[j] = '0;
                        end
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_NDIV;
                    end
                end
            end
            ST_NDIV: begin
                ndiv = {1'b0, nm_reg[axis_reg][29:0], 14'b0} + {14'b0, len_reg[31:1]};
                if (!launched_reg) begin
                    ctl.start     = 1'b1;
                    ctl.steps     = NRM_STEPS;
                    ux            = {ndiv, 83'b0};
                    ud            = {30'b0, len_reg};
                    launched_next = 1'b1;
                end else if (ures.done) begin
                    launched_next = 1'b0;
                    qn = ures.q[15:0];
                    nrm_next[axis_reg] = rneg_reg[axis_reg] ? -$signed(qn) : $signed(qn);
                    axis_next = axis_reg + 2'd1;
                    if (axis_reg == 2'd2) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    o_hit_next     = have_reg;
                    o_idx_next     = have_reg ? 6'(best_idx_reg) : 6'd0;
                    o_dist_next    = have_reg ? best_reg : 31'd0;
                    for (int j = 0; j < 3; j++) begin
                        o_pt_next[j]  = have_reg ? pt_reg[j] : 32'sd0;
                        o_nrm_next[j] = have_reg ? nrm_reg[j] : 16'sd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            spheres_reg   <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            mcnt_reg      <= '0;
            axis_reg      <= '0;
            launched_reg  <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            spheres_reg   <= spheres_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            mcnt_reg      <= mcnt_next;
            axis_reg      <= axis_next;
            launched_reg  <= launched_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
        org_reg      <= org_next;
        dir_reg      <= dir_next;
        ds_reg       <= ds_next;
        os_reg       <= os_next;
        o_reg        <= o_next;
        best_o_reg   <= best_o_next;
        sd_reg       <= sd_next;
        so_reg       <= so_next;
        rs_reg       <= rs_next;
        prod_reg     <= prod_next;
        acc_a_reg    <= acc_a_next;
        acc_b_reg    <= acc_b_next;
        acc_c_reg    <= acc_c_next;
        bm_reg       <= bm_next;
        cm_reg       <= cm_next;
        am_reg       <= am_next;
        num_reg      <= num_next;
        cneg_reg     <= cneg_next;
        disc_reg     <= disc_next;
        t_reg        <= t_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        pt_reg       <= pt_next;
        rneg_reg     <= rneg_next;
        nm_reg       <= nm_next;
        len2_reg     <= len2_next;
        len_reg      <= len_next;
        nrm_reg      <= nrm_next;
        o_hit_reg    <= o_hit_next;
        o_idx_reg    <= o_idx_next;
        o_dist_reg   <= o_dist_next;
        o_pt_reg     <= o_pt_next;
        o_nrm_reg    <= o_nrm_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_hit          = o_hit_reg;
    assign m_hit_index    = o_idx_reg;
    assign m_hit_distance = o_dist_reg;
    assign m_point_x      = o_pt_reg[0];
    assign m_point_y      = o_pt_reg[1];
    assign m_point_z      = o_pt_reg[2];
    assign m_normal_x     = o_nrm_reg[0];
    assign m_normal_y     = o_nrm_reg[1];
    assign m_normal_z     = o_nrm_reg[2];

endmodule

// File: sim/ray_sphere_closest_hit_tb.sv
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_tb
// Self-checking bench for the ray/sphere closest-hit block. Table writes and
// rays are queued by a stimulus process and driven by a clocked driver; every
// accepted ray is traced through a local copy of the sphere table and the hit
// record it must produce is queued. A clocked monitor compares each returned
// hit record with the oldest queued one. Both channels idle at random, the
// receiver holds off once for a long stretch, and spheres_in_use is moved
// through several settings over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit_tb
    import rsch_pkg::*;
;

    localparam int                   MAX_BALLS = 64;
    localparam longint unsigned      MANT_LIM  = 64'd1 << 30;
    localparam longint unsigned      DIST_MAX  = 64'h7FFF_FFFF;
    localparam logic                 MODE_WRITE = 1'b0;
    localparam logic                 MODE_TRACE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [5:0]  idx;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] rad;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
    } word_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  idx;
        logic [30:0] tval;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
    } hit_rec_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready;
    logic        m_hit;
    logic [5:0]  m_hit_index;
    logic [30:0] m_hit_distance;
    logic signed [31:0] m_point_x;
    logic signed [31:0] m_point_y;
    logic signed [31:0] m_point_z;
    logic signed [15:0] m_normal_x;
    logic signed [15:0] m_normal_y;
    logic signed [15:0] m_normal_z;

    word_t    tx_word;
    word_t    pending_words[$];
    hit_rec_t due_hits[$];
    logic     send_hold;
    logic     rx_hold;
    int       bad_words;
    int       hits_seen;
    int       rays_taken;

    longint          ball_cx[MAX_BALLS];
    longint          ball_cy[MAX_BALLS];
    longint          ball_cz[MAX_BALLS];
    longint unsigned ball_r[MAX_BALLS];
    int              live_count;
    longint          ray_org[3];
    longint          ray_dir[3];

    wire calm = (hits_seen >= 300) && (hits_seen < 500);

    ray_sphere_closest_hit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(tx_word.mode), .s_entry_index(tx_word.idx),
        .s_center_x(tx_word.cx), .s_center_y(tx_word.cy), .s_center_z(tx_word.cz),
        .s_sphere_radius(tx_word.rad),
        .s_origin_x(tx_word.ox), .s_origin_y(tx_word.oy), .s_origin_z(tx_word.oz),
        .s_dir_x(tx_word.dx), .s_dir_y(tx_word.dy), .s_dir_z(tx_word.dz),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_hit_index(m_hit_index), .m_hit_distance(m_hit_distance),
        .m_point_x(m_point_x), .m_point_y(m_point_y), .m_point_z(m_point_z),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100000000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic int unsigned norm_shift(longint unsigned m0, longint unsigned m1,
                                               longint unsigned m2, longint unsigned m3);
        int unsigned s;
        s = 0;
        while (s < 63 && ((m0 >> s) >= MANT_LIM || (m1 >> s) >= MANT_LIM ||
                          (m2 >> s) >= MANT_LIM || (m3 >> s) >= MANT_LIM))
            s++;
        return s;
    endfunction

    function automatic longint shrink(longint v, int unsigned s);
        longint unsigned m;
        m = mag(v) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned root128(logic [127:0] x);
        longint unsigned r;
        longint unsigned c;
        logic [127:0] cc;
        r = 0;
        for (int k = 62; k >= 0; k--) begin
            c = r | (64'd1 << k);
            cc = {64'd0, c} * {64'd0, c};
            if (x >= cc)
                r = c;
        end
        return r;
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            c = r | (64'd1 << k);
            if (c * c <= x)
                r = c;
        end
        return r;
    endfunction

    // smaller root of ball i for the current ray, 0 on a miss
    function automatic longint unsigned ball_root(int i);
        longint o[3];
        longint os[3];
        longint ds[3];
        longint b;
        longint c;
        longint unsigned a;
        longint unsigned rs;
        longint unsigned bm;
        longint unsigned sq;
        longint unsigned num;
        longint unsigned q;
        longint unsigned rem;
        int unsigned so;
        int unsigned sd;
        int k;
        logic signed [127:0] bw;
        logic signed [127:0] aw;
        logic signed [127:0] cw;
        logic signed [127:0] disc;
        o[0] = ray_org[0] - ball_cx[i];
        o[1] = ray_org[1] - ball_cy[i];
        o[2] = ray_org[2] - ball_cz[i];
        so = norm_shift(mag(o[0]), mag(o[1]), mag(o[2]), ball_r[i]);
        sd = norm_shift(mag(ray_dir[0]), mag(ray_dir[1]), mag(ray_dir[2]), 0);
        for (int j = 0; j < 3; j++) begin
            os[j] = shrink(o[j], so);
            ds[j] = shrink(ray_dir[j], sd);
        end
        rs = ball_r[i] >> so;
        a = ds[0] * ds[0] + ds[1] * ds[1] + ds[2] * ds[2];
        if (a == 0)
            return 0;
        b = ds[0] * os[0] + ds[1] * os[1] + ds[2] * os[2];
        c = os[0] * os[0] + os[1] * os[1] + os[2] * os[2] - longint'(rs * rs);
        if (b >= 0)
            return 0;
        bw = b;
        cw = c;
        aw = {64'd0, a};
        disc = bw * bw - aw * cw;
        if (disc < 0)
            return 0;
        sq = root128(disc);
        bm = mag(b);
        if (bm <= sq)
            return 0;
        num = bm - sq;
        q = num / a;
        rem = num % a;
        k = 16 + int'(so) - int'(sd);
        for (int n = 0; n < k && q <= DIST_MAX; n++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= a) begin
                rem = rem - a;
                q = q | 64'd1;
            end
        end
        return q > DIST_MAX ? DIST_MAX : q;
    endfunction

    function automatic hit_rec_t trace_ray();
        hit_rec_t r;
        longint unsigned best;
        longint unsigned t;
        longint unsigned m[3];
        longint unsigned len2;
        longint unsigned len;
        longint rel[3];
        longint step;
        longint pt;
        longint nmag;
        int best_i;
        int cnt;
        int unsigned s;
        logic [31:0] pv[3];
        logic [15:0] nv[3];
        r = '0;
        best = 0;
        best_i = 0;
        cnt = live_count > MAX_BALLS ? MAX_BALLS : live_count;
        for (int i = 0; i < cnt; i++) begin
            t = ball_root(i);
            if (t != 0 && (best == 0 || t < best)) begin
                best = t;
                best_i = i;
            end
        end
        if (best == 0)
            return r;
        rel[0] = ray_org[0] - ball_cx[best_i];
        rel[1] = ray_org[1] - ball_cy[best_i];
        rel[2] = ray_org[2] - ball_cz[best_i];
        for (int j = 0; j < 3; j++) begin
            step = (ray_dir[j] * longint'(best)) >>> 16;
            pt = ray_org[j] + step;
            if (pt > 64'sd2147483647)
                pt = 64'sd2147483647;
            if (pt < -64'sd2147483648)
                pt = -64'sd2147483648;
            pv[j] = pt[31:0];
            rel[j] = rel[j] + step;
            m[j] = mag(rel[j]);
            nv[j] = '0;
        end
        s = norm_shift(m[0], m[1], m[2], 0);
        len2 = 0;
        for (int j = 0; j < 3; j++) begin
            m[j] = m[j] >> s;
            len2 = len2 + m[j] * m[j];
        end
        len = root64(len2);
        if (len != 0) begin
            for (int j = 0; j < 3; j++) begin
                nmag = longint'((m[j] * 16384 + len / 2) / len);
                nmag = rel[j] < 0 ? -nmag : nmag;
                nv[j] = nmag[15:0];
            end
        end
        r.hit = 1'b1;
        r.idx = 6'(best_i);
        r.tval = best[30:0];
        r.px = pv[0];
        r.py = pv[1];
        r.pz = pv[2];
        r.nx = nv[0];
        r.ny = nv[1];
        r.nz = nv[2];
        return r;
    endfunction

    task automatic absorb(word_t w);
        if (w.mode == MODE_WRITE) begin
            ball_cx[w.idx] = longint'($signed(w.cx));
            ball_cy[w.idx] = longint'($signed(w.cy));
            ball_cz[w.idx] = longint'($signed(w.cz));
            ball_r[w.idx] = {33'd0, w.rad};
        end else begin
            ray_org[0] = longint'($signed(w.ox));
            ray_org[1] = longint'($signed(w.oy));
            ray_org[2] = longint'($signed(w.oz));
            ray_dir[0] = longint'($signed(w.dx));
            ray_dir[1] = longint'($signed(w.dy));
            ray_dir[2] = longint'($signed(w.dz));
            due_hits.push_back(trace_ray());
            rays_taken++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                absorb(tx_word);
            if (!s_valid || s_ready) begin
                if (!send_hold && pending_words.size() > 0 &&
                    (calm || $urandom_range(99) >= 15)) begin
                    tx_word <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        hit_rec_t want;
        hit_rec_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                hits_seen++;
                got = {m_hit, m_hit_index, m_hit_distance, m_point_x, m_point_y, m_point_z,
                       m_normal_x, m_normal_y, m_normal_z};
                if (due_hits.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("unexpected hit word %h", got);
                end else begin
                    want = due_hits.pop_front();
                    if (got !== want) begin
                        bad_words++;
                        if (bad_words <= 10)
                            $display("hit %0d: exp hit=%b idx=%0d t=%h p=%h,%h,%h n=%h,%h,%h",
                                     hits_seen, want.hit, want.idx, want.tval, want.px,
                                     want.py, want.pz, want.nx, want.ny, want.nz,
                                     "\n        got hit=%b idx=%0d t=%h p=%h,%h,%h n=%h,%h,%h",
                                     got.hit, got.idx, got.tval, got.px, got.py, got.pz,
                                     got.nx, got.ny, got.nz);
                    end
                end
            end
            m_ready <= !rx_hold && (calm || $urandom_range(99) >= 15);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        rx_hold = 1'b0;
        wait (rays_taken >= 60);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (3000) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    function automatic int srand(int unsigned span);
        return int'($urandom_range(2 * span)) - int'(span);
    endfunction

    function automatic word_t sphere_word(int idx, bit wild);
        word_t w;
        w = '0;
        w.mode = MODE_WRITE;
        w.idx = 6'(idx);
        if (wild) begin
            w.cx = $urandom;
            w.cy = $urandom;
            w.cz = $urandom;
            w.rad = 31'($urandom);
        end else begin
            w.cx = srand(1 << 24);
            w.cy = srand(1 << 24);
            w.cz = srand(1 << 24);
            w.rad = 31'($urandom_range(1 << 22, 1));
        end
        w.ox = $urandom;
        w.oy = $urandom;
        w.oz = $urandom;
        w.dx = $urandom;
        w.dy = $urandom;
        w.dz = $urandom;
        return w;
    endfunction

    function automatic word_t ray_word(bit aimed, int k);
        word_t w;
        int off[3];
        longint org;
        longint cen;
        int unsigned jit;
        int unsigned sh;
        w = '0;
        w.mode = MODE_TRACE;
        w.idx = $urandom;
        w.cx = $urandom;
        w.cy = $urandom;
        w.cz = $urandom;
        w.rad = 31'($urandom);
        w.ox = $urandom;
        w.oy = $urandom;
        w.oz = $urandom;
        w.dx = $urandom;
        w.dy = $urandom;
        w.dz = $urandom;
        if (aimed) begin
            jit = ball_r[k] / 2 > (1 << 24) ? (1 << 24) : int'(ball_r[k] / 2);
            sh = $urandom_range(12);
            for (int j = 0; j < 3; j++) begin
                cen = j == 0 ? ball_cx[k] : (j == 1 ? ball_cy[k] : ball_cz[k]);
                off[j] = srand(1 << 26);
                org = cen + off[j];
                if (org > 64'sd2147483647 || org < -64'sd2147483648)
                    org = cen;
                case (j)
                    0: begin w.ox = org[31:0]; w.dx = (-off[j] + srand(jit)) >>> sh; end
                    1: begin w.oy = org[31:0]; w.dy = (-off[j] + srand(jit)) >>> sh; end
                    default: begin w.oz = org[31:0]; w.dz = (-off[j] + srand(jit)) >>> sh; end
                endcase
            end
        end
        return w;
    endfunction

    task automatic wait_idle();
        do begin
            while (pending_words.size() > 0 || s_valid || due_hits.size() > 0 || !s_ready)
                @(posedge aclk);
            repeat (20) @(posedge aclk);
        end while (pending_words.size() > 0 || s_valid || due_hits.size() > 0 || !s_ready);
    endtask

    task automatic write_count(int v);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_SPHERES) * 3'd4;
        pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        live_count = v & 8'h7F;
        @(posedge aclk);
    endtask

    // one phase: table rewrites and rays, mostly aimed at balls in use
    task automatic run_phase(int cnt, int items);
        int lim;
        int roll;
        lim = cnt > MAX_BALLS ? MAX_BALLS : cnt;
        write_count(cnt);
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(99);
            if (roll < 35)
                pending_words.push_back(sphere_word($urandom_range(63), $urandom_range(4) == 0));
            else if (roll < 85)
                pending_words.push_back(ray_word(1'b1, lim > 0 ? $urandom_range(lim - 1)
                                                                : $urandom_range(63)));
            else
                pending_words.push_back(ray_word(1'b0, 0));
            if (n == items / 2) begin
                while (pending_words.size() > 0)
                    @(posedge aclk);
                send_hold <= 1'b1;
                wait_idle();
                send_hold <= 1'b0;
            end
        end
    endtask

    initial begin
        word_t w;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        tx_word = '0;
        send_hold = 1'b0;
        bad_words = 0;
        hits_seen = 0;
        rays_taken = 0;
        live_count = 0;
        for (int i = 0; i < MAX_BALLS; i++) begin
            ball_cx[i] = 0;
            ball_cy[i] = 0;
            ball_cz[i] = 0;
            ball_r[i] = 0;
        end
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < MAX_BALLS; i++)
            pending_words.push_back(sphere_word(i, 1'b0));
        pending_words.push_back(ray_word(1'b0, 0));
        write_count(0);

        // radius-zero ball at the origin, two identical balls, one extreme ball
        w = sphere_word(0, 1'b0);
        w.cx = '0; w.cy = '0; w.cz = '0; w.rad = '0;
        pending_words.push_back(w);
        w = sphere_word(1, 1'b0);
        w.cx = 32'sd1000 <<< 16; w.cy = '0; w.cz = '0; w.rad = 31'd1 << 18;
        pending_words.push_back(w);
        w.idx = 6'd2;
        pending_words.push_back(w);
        w = sphere_word(3, 1'b0);
        w.cx = 32'h7FFF_FFFF; w.cy = 32'h8000_0000; w.cz = 32'h7FFF_FFFF;
        w.rad = 31'h7FFF_FFFF;
        pending_words.push_back(w);
        write_count(4);
        // straight through the radius-zero ball: hit point on the center
        w = ray_word(1'b0, 0);
        w.ox = -(32'sd5 <<< 16); w.oy = '0; w.oz = '0;
        w.dx = 32'sd1 <<< 16; w.dy = '0; w.dz = '0;
        pending_words.push_back(w);
        // toward the tied pair
        w.ox = 32'sd900 <<< 16; w.dx = 32'sd3 <<< 16;
        pending_words.push_back(w);
        // zero direction
        w.dx = '0;
        pending_words.push_back(w);
        // origin inside the extreme ball
        w.ox = 32'h7FFF_0000; w.oy = 32'h8000_1000; w.oz = 32'h7FFF_0000;
        w.dx = 32'h8000_0000; w.dy = 32'h7FFF_FFFF; w.dz = 32'h8000_0000;
        pending_words.push_back(w);
        // extreme origin and direction
        w.ox = 32'h8000_0000; w.oy = 32'h7FFF_FFFF; w.oz = 32'h8000_0000;
        w.dx = 32'h7FFF_FFFF; w.dy = 32'h8000_0000; w.dz = 32'h7FFF_FFFF;
        pending_words.push_back(w);
        w.ox = 32'h7FFF_FFFF; w.oy = 32'h8000_0000; w.oz = 32'h7FFF_FFFF;
        w.dx = 32'h8000_0000; w.dy = 32'h7FFF_FFFF; w.dz = 32'h8000_0000;
        pending_words.push_back(w);
        pending_words.push_back(ray_word(1'b1, 1));

        run_phase(1, 250);
        run_phase(2, 250);
        run_phase(3, 200);
        run_phase(4, 200);
        run_phase(0, 60);
        run_phase(8, 80);
        run_phase(64, 12);
        run_phase(5, 150);
        run_phase(127, 8);
        run_phase(1, 160);

        wait_idle();
        repeat (300) @(posedge aclk);
        if (bad_words == 0 && due_hits.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
